FILE: rtl/lact_pkg.sv
// ----------------------------------------------------------------------------
// lact_pkg
// Shared types and operation codes for the linear association counter table.
// ----------------------------------------------------------------------------
package lact_pkg;

    // Operation codes
    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_INCREMENT = 2'd1;
    localparam logic [1:0] OP_LOOKUP    = 2'd2;
    localparam logic [1:0] OP_CLEAR     = 2'd3;

    // Field widths of one transaction
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 7;

    // Request transaction
    typedef struct packed {
        logic [1:0]         operation;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    // Response transaction
    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        logic               found;
        logic               full_res;
        logic [COUNT_W-1:0] entry_count;
    } t_out_item;

endpackage

FILE: rtl/linear_assoc_counter_table.sv
// ----------------------------------------------------------------------------
// linear_assoc_counter_table
// Fixed-depth key/value table with linear first-match search, used for
// insert-if-absent, counting, lookup and clear.
// ----------------------------------------------------------------------------
// Sequence: clear goes straight to the response; other operations scan keys
//   from entry 0; a hit reads (and on increment updates) the value, a miss
//   appends unless it is a lookup or the table is full. Throughput: one
//   transaction at a time; the key memory read port steps one entry per cycle.
// Reset: synchronous, active low; the table comes up empty, the memories are
//   not cleared and only entries below the fill count are ever read.
module linear_assoc_counter_table #(
    parameter int unsigned TABLE_DEPTH = 64,
    parameter int unsigned KEY_BITS    = 32,
    parameter int unsigned VALUE_BITS  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lact_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lact_pkg::t_out_item o_out_data
);
    import lact_pkg::*;

    localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned KIN = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int unsigned VIN = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_VRD  = 3'd3;
    localparam logic [2:0] S_VUPD = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // Table storage
    logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];

    // Control registers
    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic                  r_out_vld, n_out_vld;

    // Datapath registers
    logic [1:0]            r_op, n_op;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [AW-1:0]         r_pidx, n_pidx;
    logic [AW-1:0]         r_midx, n_midx;
    logic [VALUE_BITS-1:0] r_res, n_res;
    logic                  r_found, n_found;
    logic                  r_full, n_full;
    t_out_item             r_out, n_out;
    logic [KEY_BITS-1:0]   r_key_q;
    logic [VALUE_BITS-1:0] r_val_q;

    // Memory port controls
    logic                  w_key_rd;
    logic                  w_val_rd;
    logic                  w_key_we;
    logic                  w_val_we;
    logic [AW-1:0]         w_wr_addr;
    logic [VALUE_BITS-1:0] w_val_wdata;
    logic                  w_in_acc;
    logic                  w_hit;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Compare of the key read in the previous scan cycle
    assign w_hit = (r_state == S_SCAN) && r_pend && (r_key_q == r_key);

    // Sequencer and next-value logic
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_out_vld   = r_out_vld && i_out_stall;
        n_op        = r_op;
        n_key       = r_key;
        n_val       = r_val;
        n_pidx      = r_pidx;
        n_midx      = r_midx;
        n_res       = r_res;
        n_found     = r_found;
        n_full      = r_full;
        n_out       = r_out;
        w_key_rd    = 1'b0;
        w_val_rd    = 1'b0;
        w_key_we    = 1'b0;
        w_val_we    = 1'b0;
        w_wr_addr   = r_midx;
        w_val_wdata = r_val_q;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op    = i_in_data.operation;
                    n_key   = KEY_BITS'(i_in_data.key[KIN-1:0]);
                    n_val   = VALUE_BITS'(i_in_data.value[VIN-1:0]);
                    n_res   = '0;
                    n_found = 1'b0;
                    n_full  = 1'b0;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    if (i_in_data.operation == OP_CLEAR) begin
                        n_count = '0;
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        n_state = S_ADD;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_midx  = r_pidx;
                    n_pend  = 1'b0;
                    n_state = S_VRD;
                end else if (r_idx == r_count) begin
                    n_pend  = 1'b0;
                    n_state = S_ADD;
                end else begin
                    // Issue the next key read
                    w_key_rd = 1'b1;
                    n_pidx   = r_idx[AW-1:0];
                    n_idx    = CW'(r_idx + 1'b1);
                    n_pend   = 1'b1;
                end
            end
            S_ADD: begin
                if (r_op == OP_LOOKUP) begin
                    n_state = S_DONE;
                end else if (r_count == CW'(TABLE_DEPTH)) begin
                    n_full  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    // Append the new key at the fill position
                    w_key_we    = 1'b1;
                    w_val_we    = 1'b1;
                    w_wr_addr   = r_count[AW-1:0];
                    w_val_wdata = (r_op == OP_INSERT) ? r_val : VALUE_BITS'(1);
                    n_res       = w_val_wdata;
                    n_count     = CW'(r_count + 1'b1);
                    n_state     = S_DONE;
                end
            end
            S_VRD: begin
                w_val_rd = 1'b1;
                n_state  = S_VUPD;
            end
            S_VUPD: begin
                n_found = 1'b1;
                if (r_op == OP_INCREMENT) begin
                    w_val_we    = 1'b1;
                    w_wr_addr   = r_midx;
                    w_val_wdata = r_val_q + VALUE_BITS'(1);
                    n_res       = w_val_wdata;
                end else begin
                    n_res = r_val_q;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // Move the response into the output register once it is free
                if (!r_out_vld || !i_out_stall) begin
                    n_out.result_value = VALUE_W'(r_res[VIN-1:0]);
                    n_out.found        = r_found;
                    n_out.full_res     = r_full;
                    n_out.entry_count  = COUNT_W'(r_count);
                    n_out_vld          = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_key   <= n_key;
        r_val   <= n_val;
        r_pidx  <= n_pidx;
        r_midx  <= n_midx;
        r_res   <= n_res;
        r_found <= n_found;
        r_full  <= n_full;
        r_out   <= n_out;
    end

    // Key memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            key_mem[w_wr_addr] <= r_key;
        end
        if (w_key_rd) begin
            r_key_q <= key_mem[r_idx[AW-1:0]];
        end
    end

    // Value memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_val_we) begin
            val_mem[w_wr_addr] <= w_val_wdata;
        end
        if (w_val_rd) begin
            r_val_q <= val_mem[r_midx];
        end
    end

`ifndef SYNTHESIS
    // Fill count never exceeds the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // Scan pointer stays within the filled region
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_count))
        else $error("scan index past fill count");

    // A clear empties the table by the next cycle
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.operation == OP_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the table");

    // A dropped key only happens on a full table and reports no value
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.full_res) |->
            (!o_out_data.found && o_out_data.result_value == '0 &&
             o_out_data.entry_count == COUNT_W'(TABLE_DEPTH)))
        else $error("drop response inconsistent");
`endif

endmodule
